// ----- hdl/masked_inpaint_diffusion_macros.svh -----
// ---------------------------------------------------------------------------
// masked_inpaint_diffusion_macros.svh
// Assertion macros for the masked inpaint diffusion block.
// ---------------------------------------------------------------------------
`ifndef MASKED_INPAINT_DIFFUSION_MACROS_SVH
`define MASKED_INPAINT_DIFFUSION_MACROS_SVH

`ifndef SYNTH
// check on every clock edge out of reset
`define MID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on every clock edge, reset included
`define MID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MID_ASSERT(lbl, prop, msg)
`define MID_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/mid_pkg.sv -----
// ---------------------------------------------------------------------------
// mid_pkg
// Shared types and constants of the masked inpaint diffusion block.
// ---------------------------------------------------------------------------
package mid_pkg;

  localparam int unsigned MaxWidthDefault  = 64;
  localparam int unsigned MaxHeightDefault = 64;

  localparam int unsigned DimW   = 7;
  localparam int unsigned SweepW = 8;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PosW   = 6;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] MaskThreshold = 8'd128;

  localparam logic [OpW-1:0] OP_WRITE = 2'd0;
  localparam logic [OpW-1:0] OP_READ  = 2'd1;
  localparam logic [OpW-1:0] OP_RUN   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SWEEP_COUNT  = 2'd2;

  localparam logic [DimW-1:0]   ImageWidthReset  = 7'd64;
  localparam logic [DimW-1:0]   ImageHeightReset = 7'd64;
  localparam logic [SweepW-1:0] SweepCountReset  = 8'd1;

  typedef struct packed {
    logic             mask;
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [SweepW-1:0] sweeps;
  } run_cfg_t;

endpackage

// ----- hdl/mid_ram.sv -----
// ---------------------------------------------------------------------------
// mid_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module mid_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mid_sweep.sv -----
// ---------------------------------------------------------------------------
// mid_sweep
// Diffusion sweep sequencer: walks the interior pixels in raster order and
// rewrites masked pixels with the mean of their four neighbors.
// ---------------------------------------------------------------------------
module mid_sweep #(
  parameter int unsigned MAX_WIDTH  = mid_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = mid_pkg::MaxHeightDefault
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 start_i,
  input  mid_pkg::run_cfg_t                                    cfg_i,
  output logic                                                 done_o,
  output logic                                                 busy_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]      raddr_o,
  input  mid_pkg::pixel_t                                      rdata_i,
  output logic                                                 we_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]      waddr_o,
  output mid_pkg::pixel_t                                      wdata_o
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned XYW = (XW > YW) ? XW : YW;
  localparam int unsigned CW  = ((XYW > mid_pkg::DimW) ? XYW : mid_pkg::DimW) + 1;
  localparam int unsigned SumW = mid_pkg::ChanW + 2;

  typedef enum logic [2:0] {S_IDLE, S_CTR, S_UP, S_DN, S_LF, S_RT, S_WR} state_e;

  state_e                     state_q, state_d;
  logic [XW-1:0]              x_q, x_d;
  logic [YW-1:0]              y_q, y_d;
  logic [mid_pkg::SweepW-1:0] s_q, s_d;
  logic [SumW-1:0]            acc_r_q, acc_r_d, acc_g_q, acc_g_d, acc_b_q, acc_b_d;
  logic [SumW-1:0]            sum_r, sum_g, sum_b;
  mid_pkg::pixel_t            ctr_q, ctr_d;
  logic                       done_q, done_d;
  logic                       x_last, y_last, s_last, no_work;
  logic [XW+YW-1:0]           addr_ctr, addr_up, addr_dn, addr_lf, addr_rt;

  assign x_last = (CW'(x_q) + CW'(2)) >= CW'(cfg_i.width);
  assign y_last = (CW'(y_q) + CW'(2)) >= CW'(cfg_i.height);
  assign s_last = s_q == (cfg_i.sweeps - mid_pkg::SweepW'(1));
  assign no_work = (cfg_i.width < mid_pkg::DimW'(3)) || (cfg_i.height < mid_pkg::DimW'(3))
                   || (cfg_i.sweeps == '0);

  assign addr_ctr = {y_q, x_q};
  assign addr_up  = {y_q - YW'(1), x_q};
  assign addr_dn  = {y_q + YW'(1), x_q};
  assign addr_lf  = {y_q, x_q - XW'(1)};
  assign addr_rt  = {y_q, x_q + XW'(1)};

  assign sum_r = acc_r_q + SumW'(rdata_i.red);
  assign sum_g = acc_g_q + SumW'(rdata_i.green);
  assign sum_b = acc_b_q + SumW'(rdata_i.blue);

  always_comb begin
    case (state_q)
      S_UP:    raddr_o = addr_up;
      S_DN:    raddr_o = addr_dn;
      S_LF:    raddr_o = addr_lf;
      S_RT:    raddr_o = addr_rt;
      default: raddr_o = addr_ctr;
    endcase
  end

  assign we_o          = state_q == S_WR;
  assign waddr_o       = addr_ctr;
  assign wdata_o.mask  = ctr_q.mask;
  assign wdata_o.alpha = ctr_q.alpha;
  assign wdata_o.red   = sum_r[SumW-1:2];
  assign wdata_o.green = sum_g[SumW-1:2];
  assign wdata_o.blue  = sum_b[SumW-1:2];

  assign done_o = done_q;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    logic advance;
    advance = 1'b0;
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    s_d     = s_q;
    acc_r_d = acc_r_q;
    acc_g_d = acc_g_q;
    acc_b_d = acc_b_q;
    ctr_d   = ctr_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (no_work) begin
            done_d = 1'b1;
          end else begin
            x_d     = XW'(1);
            y_d     = YW'(1);
            s_d     = '0;
            state_d = S_CTR;
          end
        end
      end
      S_CTR: state_d = S_UP;
      S_UP: begin
        ctr_d = rdata_i;
        if (rdata_i.mask) begin
          state_d = S_DN;
        end else begin
          advance = 1'b1;
        end
      end
      S_DN: begin
        acc_r_d = SumW'(rdata_i.red);
        acc_g_d = SumW'(rdata_i.green);
        acc_b_d = SumW'(rdata_i.blue);
        state_d = S_LF;
      end
      S_LF: begin
        acc_r_d = sum_r;
        acc_g_d = sum_g;
        acc_b_d = sum_b;
        state_d = S_RT;
      end
      S_RT: begin
        acc_r_d = sum_r;
        acc_g_d = sum_g;
        acc_b_d = sum_b;
        state_d = S_WR;
      end
      S_WR: advance = 1'b1;
      default: state_d = S_IDLE;
    endcase
    if (advance) begin
      state_d = S_CTR;
      if (!x_last) begin
        x_d = x_q + XW'(1);
      end else begin
        x_d = XW'(1);
        if (!y_last) begin
          y_d = y_q + YW'(1);
        end else begin
          y_d = YW'(1);
          if (!s_last) begin
            s_d = s_q + mid_pkg::SweepW'(1);
          end else begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      s_q     <= '0;
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
      ctr_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      x_q     <= x_d;
      y_q     <= y_d;
      s_q     <= s_d;
      acc_r_q <= acc_r_d;
      acc_g_q <= acc_g_d;
      acc_b_q <= acc_b_d;
      ctr_q   <= ctr_d;
    end
  end

endmodule

// ----- hdl/masked_inpaint_diffusion.sv -----
// ---------------------------------------------------------------------------
// masked_inpaint_diffusion
// RGBA frame store with per-pixel mask and in-place diffusion inpainting.
// ---------------------------------------------------------------------------
// Every item gives one result through an output register, so a new item is
// taken while the last result waits as long as that register drains. A pixel
// write, an out-of-range read or write and an unused opcode have their result
// registered in the cycle after they are taken; an in-range read first passes
// through the frame store's registered read. During a run the single read port
// of the frame store fetches the center pixel and then, for a masked pixel,
// its four neighbors one after another before the write-back. The store needs
// no clearing after reset; pixels are defined once written.
// ---------------------------------------------------------------------------
module masked_inpaint_diffusion #(
  parameter int unsigned MAX_WIDTH  = mid_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = mid_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mid_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mid_pkg::SweepW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mid_pkg::OpW-1:0]       op_i,
  input  logic [mid_pkg::PosW-1:0]      pos_x_i,
  input  logic [mid_pkg::PosW-1:0]      pos_y_i,
  input  logic [mid_pkg::ChanW-1:0]     red_in_i,
  input  logic [mid_pkg::ChanW-1:0]     green_in_i,
  input  logic [mid_pkg::ChanW-1:0]     blue_in_i,
  input  logic [mid_pkg::ChanW-1:0]     alpha_in_i,
  input  logic [mid_pkg::ChanW-1:0]     mask_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mid_pkg::ChanW-1:0]     red_out_o,
  output logic [mid_pkg::ChanW-1:0]     green_out_o,
  output logic [mid_pkg::ChanW-1:0]     blue_out_o,
  output logic [mid_pkg::ChanW-1:0]     alpha_out_o,
  output logic                          masked_out_o,
  output logic                          status_o
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 2 ** AW;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RUN} state_e;

  state_e                      state_q, state_d;
  logic [mid_pkg::DimW-1:0]    width_q, height_q;
  logic [mid_pkg::SweepW-1:0]  sweeps_q;
  logic [mid_pkg::DimW-1:0]    eff_width, eff_height;
  mid_pkg::run_cfg_t           run_cfg;
  logic                        out_valid_q, out_valid_d;
  mid_pkg::pixel_t             out_pix_q, out_pix_d;
  logic                        status_q, status_d;
  logic                        accept, in_range, run_start;
  logic [AW-1:0]               host_addr;
  mid_pkg::pixel_t             host_pix, ram_wdata, ram_rdata, sweep_wdata;
  logic                        ram_we, sweep_we, sweep_done, sweep_busy;
  logic [AW-1:0]               ram_waddr, ram_raddr, sweep_waddr, sweep_raddr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mid_pkg::ImageWidthReset;
      height_q <= mid_pkg::ImageHeightReset;
      sweeps_q <= mid_pkg::SweepCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mid_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[mid_pkg::DimW-1:0];
        mid_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[mid_pkg::DimW-1:0];
        mid_pkg::CFG_SWEEP_COUNT:  sweeps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_width = mid_pkg::DimW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_width = mid_pkg::DimW'(MAX_WIDTH);
    end else begin
      eff_width = width_q;
    end
    if (height_q == '0) begin
      eff_height = mid_pkg::DimW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_height = mid_pkg::DimW'(MAX_HEIGHT);
    end else begin
      eff_height = height_q;
    end
  end

  assign run_cfg.width  = eff_width;
  assign run_cfg.height = eff_height;
  assign run_cfg.sweeps = sweeps_q;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (mid_pkg::DimW'(pos_x_i) < eff_width)
                      && (mid_pkg::DimW'(pos_y_i) < eff_height);
  assign host_addr  = {YW'(pos_y_i), XW'(pos_x_i)};

  assign host_pix.mask  = mask_level_i >= mid_pkg::MaskThreshold;
  assign host_pix.alpha = alpha_in_i;
  assign host_pix.blue  = blue_in_i;
  assign host_pix.green = green_in_i;
  assign host_pix.red   = red_in_i;

  assign ram_we    = sweep_we || (accept && (op_i == mid_pkg::OP_WRITE) && in_range);
  assign ram_waddr = sweep_we ? sweep_waddr : host_addr;
  assign ram_wdata = sweep_we ? sweep_wdata : host_pix;
  assign ram_raddr = (state_q == ST_IDLE) ? host_addr : sweep_raddr;

  mid_ram #(
    .Width ($bits(mid_pkg::pixel_t)),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mid_sweep #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (run_start),
    .cfg_i   (run_cfg),
    .done_o  (sweep_done),
    .busy_o  (sweep_busy),
    .raddr_o (sweep_raddr),
    .rdata_i (ram_rdata),
    .we_o    (sweep_we),
    .waddr_o (sweep_waddr),
    .wdata_o (sweep_wdata)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pix_d   = out_pix_q;
    status_d    = status_q;
    run_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            mid_pkg::OP_WRITE: begin
              out_valid_d = 1'b1;
              out_pix_d   = '0;
              status_d    = !in_range;
            end
            mid_pkg::OP_READ: begin
              if (in_range) begin
                state_d = ST_READ;
              end else begin
                out_valid_d = 1'b1;
                out_pix_d   = '0;
                status_d    = 1'b1;
              end
            end
            mid_pkg::OP_RUN: begin
              run_start = 1'b1;
              state_d   = ST_RUN;
            end
            default: begin
              out_valid_d = 1'b1;
              out_pix_d   = '0;
              status_d    = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_pix_d   = ram_rdata;
        status_d    = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_RUN: begin
        if (sweep_done) begin
          out_valid_d = 1'b1;
          out_pix_d   = '0;
          status_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      status_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_pix_q   <= out_pix_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_pix_q.red;
  assign green_out_o  = out_pix_q.green;
  assign blue_out_o   = out_pix_q.blue;
  assign alpha_out_o  = out_pix_q.alpha;
  assign masked_out_o = out_pix_q.mask;
  assign status_o     = status_q;

`include "masked_inpaint_diffusion_macros.svh"

  `MID_ASSERT(a_no_input_while_sweeping, !(sweep_busy && in_ready_o), "input taken during sweep")
  `MID_ASSERT(a_write_result_next, (accept && op_i == mid_pkg::OP_WRITE) |=> out_valid_o, "write gave no result")
  `MID_ASSERT(a_run_blocks_input, (accept && op_i == mid_pkg::OP_RUN) |=> !in_ready_o, "run did not block input")
  `MID_ASSERT(a_sweep_write_only_in_run, sweep_we |-> (state_q == ST_RUN), "sweep write outside a run")

endmodule

// ----- dv/tb_masked_inpaint_diffusion.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_masked_inpaint_diffusion
// Self-checking bench for the masked inpaint diffusion frame store.
// ---------------------------------------------------------------------------
// Pixel writes, reads and inpainting runs go in through a queued driver. A
// shadow frame store with its own copy of the registers predicts every
// result, and a monitor compares each result transfer field by field.
// Runs in the random phases are only issued once the whole active image has
// been written, and reads only touch written pixels. Image size and sweep count
// change between phases, with both idling sides. One long receiver hold-off
// backs up the block.
// ---------------------------------------------------------------------------
module tb_masked_inpaint_diffusion;

  localparam int unsigned FrameW     = mid_pkg::MaxWidthDefault;
  localparam int unsigned FrameH     = mid_pkg::MaxHeightDefault;
  localparam int unsigned StoreDepth = FrameW * FrameH;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned QuietFrom  = 6_000;
  localparam int unsigned QuietTo    = 20_000;
  localparam int unsigned TargetCmds = 1700;

  localparam logic [mid_pkg::OpW-1:0]     OP_UNUSED  = 2'd3;
  localparam logic [mid_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [mid_pkg::OpW-1:0]   op;
    logic [mid_pkg::PosW-1:0]  pos_x;
    logic [mid_pkg::PosW-1:0]  pos_y;
    logic [mid_pkg::ChanW-1:0] red;
    logic [mid_pkg::ChanW-1:0] green;
    logic [mid_pkg::ChanW-1:0] blue;
    logic [mid_pkg::ChanW-1:0] alpha;
    logic [mid_pkg::ChanW-1:0] mask_level;
  } pix_cmd_t;

  typedef struct packed {
    logic [mid_pkg::ChanW-1:0] red;
    logic [mid_pkg::ChanW-1:0] green;
    logic [mid_pkg::ChanW-1:0] blue;
    logic [mid_pkg::ChanW-1:0] alpha;
    logic                      masked;
    logic                      status;
  } pix_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mid_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [mid_pkg::SweepW-1:0]  cfg_data  = '0;

  logic                      in_valid   = 1'b0;
  logic                      in_ready;
  logic [mid_pkg::OpW-1:0]   op         = '0;
  logic [mid_pkg::PosW-1:0]  pos_x      = '0;
  logic [mid_pkg::PosW-1:0]  pos_y      = '0;
  logic [mid_pkg::ChanW-1:0] red_in     = '0;
  logic [mid_pkg::ChanW-1:0] green_in   = '0;
  logic [mid_pkg::ChanW-1:0] blue_in    = '0;
  logic [mid_pkg::ChanW-1:0] alpha_in   = '0;
  logic [mid_pkg::ChanW-1:0] mask_level = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [mid_pkg::ChanW-1:0] red_out;
  logic [mid_pkg::ChanW-1:0] green_out;
  logic [mid_pkg::ChanW-1:0] blue_out;
  logic [mid_pkg::ChanW-1:0] alpha_out;
  logic                      masked_out;
  logic                      status;

  masked_inpaint_diffusion #(
    .MAX_WIDTH (FrameW),
    .MAX_HEIGHT(FrameH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .alpha_in_i  (alpha_in),
    .mask_level_i(mask_level),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .alpha_out_o (alpha_out),
    .masked_out_o(masked_out),
    .status_o    (status)
  );

  // shadow frame store and registers
  mid_pkg::pixel_t            frame_mdl [StoreDepth];
  logic [mid_pkg::DimW-1:0]   mdl_width  = mid_pkg::ImageWidthReset;
  logic [mid_pkg::DimW-1:0]   mdl_height = mid_pkg::ImageHeightReset;
  logic [mid_pkg::SweepW-1:0] mdl_sweeps = mid_pkg::SweepCountReset;

  // stimulus planning state
  bit          pix_written [StoreDepth];
  int unsigned plan_w = FrameW;
  int unsigned plan_h = FrameH;

  pix_cmd_t    pending_cmds [$];
  pix_result_t awaited_results [$];
  pix_cmd_t    cur_cmd;
  pix_result_t want;

  int unsigned cycle_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned fail_cnt     = 0;
  int unsigned pushed_cnt   = 0;
  int unsigned n_writes     = 0;
  int unsigned n_reads      = 0;
  int unsigned n_runs       = 0;
  int unsigned n_rejected   = 0;
  int unsigned n_cfg        = 0;
  int unsigned n_phases     = 0;
  logic        hold_off     = 1'b0;

  wire quiet = (cycle_cnt >= QuietFrom) && (cycle_cnt < QuietTo);

  function automatic int unsigned clamp_dim(input logic [mid_pkg::DimW-1:0] v,
                                            input int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic pix_result_t apply_cmd(input pix_cmd_t c);
    pix_result_t res;
    int unsigned ew, eh, idx, s, px, py, i, cx, cy;
    int unsigned sum_r, sum_g, sum_b;
    res = '0;
    ew = clamp_dim(mdl_width, FrameW);
    eh = clamp_dim(mdl_height, FrameH);
    cx = 32'(c.pos_x);
    cy = 32'(c.pos_y);
    case (c.op)
      mid_pkg::OP_WRITE, mid_pkg::OP_READ: begin
        if (cx >= ew || cy >= eh) begin
          res.status = 1'b1;
        end else begin
          idx = cy * FrameW + cx;
          if (c.op == mid_pkg::OP_WRITE) begin
            frame_mdl[idx].red   = c.red;
            frame_mdl[idx].green = c.green;
            frame_mdl[idx].blue  = c.blue;
            frame_mdl[idx].alpha = c.alpha;
            frame_mdl[idx].mask  = (c.mask_level >= mid_pkg::MaskThreshold);
          end else begin
            res.red    = frame_mdl[idx].red;
            res.green  = frame_mdl[idx].green;
            res.blue   = frame_mdl[idx].blue;
            res.alpha  = frame_mdl[idx].alpha;
            res.masked = frame_mdl[idx].mask;
          end
        end
      end
      mid_pkg::OP_RUN: begin
        if (ew >= 3 && eh >= 3) begin
          for (s = 0; s < 32'(mdl_sweeps); s++) begin
            for (py = 1; py + 1 < eh; py++) begin
              for (px = 1; px + 1 < ew; px++) begin
                i = py * FrameW + px;
                if (frame_mdl[i].mask) begin
                  sum_r = 32'(frame_mdl[i - FrameW].red) + 32'(frame_mdl[i + FrameW].red)
                        + 32'(frame_mdl[i - 1].red) + 32'(frame_mdl[i + 1].red);
                  sum_g = 32'(frame_mdl[i - FrameW].green) + 32'(frame_mdl[i + FrameW].green)
                        + 32'(frame_mdl[i - 1].green) + 32'(frame_mdl[i + 1].green);
                  sum_b = 32'(frame_mdl[i - FrameW].blue) + 32'(frame_mdl[i + FrameW].blue)
                        + 32'(frame_mdl[i - 1].blue) + 32'(frame_mdl[i + 1].blue);
                  frame_mdl[i].red   = mid_pkg::ChanW'(sum_r >> 2);
                  frame_mdl[i].green = mid_pkg::ChanW'(sum_g >> 2);
                  frame_mdl[i].blue  = mid_pkg::ChanW'(sum_b >> 2);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [mid_pkg::ChanW-1:0] exp_v,
                             input logic [mid_pkg::ChanW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic push_cmd(input logic [mid_pkg::OpW-1:0] c_op, input int unsigned x,
                          input int unsigned y, input int unsigned r, input int unsigned g,
                          input int unsigned b, input int unsigned a, input int unsigned m);
    pix_cmd_t c;
    bit       in_range;
    c = '{op: c_op, pos_x: mid_pkg::PosW'(x), pos_y: mid_pkg::PosW'(y),
          red: mid_pkg::ChanW'(r), green: mid_pkg::ChanW'(g), blue: mid_pkg::ChanW'(b),
          alpha: mid_pkg::ChanW'(a), mask_level: mid_pkg::ChanW'(m)};
    in_range = (x < plan_w) && (y < plan_h);
    pending_cmds.push_back(c);
    pushed_cnt++;
    case (c_op)
      mid_pkg::OP_WRITE: if (in_range) pix_written[y * FrameW + x] = 1'b1;
      mid_pkg::OP_RUN:   n_runs++;
      default: ;
    endcase
    if (c_op == mid_pkg::OP_WRITE && in_range) n_writes++;
    if (c_op == mid_pkg::OP_READ && in_range) n_reads++;
    if ((c_op == mid_pkg::OP_WRITE || c_op == mid_pkg::OP_READ) && !in_range) n_rejected++;
  endtask

  task automatic push_write(input int unsigned x, input int unsigned y);
    push_cmd(mid_pkg::OP_WRITE, x, y, $urandom_range(255), $urandom_range(255),
             $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic push_read(input int unsigned x, input int unsigned y);
    push_cmd(mid_pkg::OP_READ, x, y, $urandom_range(255), $urandom_range(255),
             $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // sample between edges so every transfer of the last edge has settled
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mid_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_index <= idx;
    cfg_data  <= mid_pkg::SweepW'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      mid_pkg::CFG_IMAGE_WIDTH: begin
        mdl_width = mid_pkg::DimW'(val);
        plan_w    = clamp_dim(mid_pkg::DimW'(val), FrameW);
      end
      mid_pkg::CFG_IMAGE_HEIGHT: begin
        mdl_height = mid_pkg::DimW'(val);
        plan_h     = clamp_dim(mid_pkg::DimW'(val), FrameH);
      end
      mid_pkg::CFG_SWEEP_COUNT: mdl_sweeps = mid_pkg::SweepW'(val);
      default: ;
    endcase
  endtask

  // configure, fill the active image, then a random mix of commands
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned sw,
                           input int unsigned nrand);
    int unsigned x, y, k, r;
    write_reg(mid_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(mid_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(mid_pkg::CFG_SWEEP_COUNT, sw);
    n_phases++;
    for (y = 0; y < plan_h; y++)
      for (x = 0; x < plan_w; x++)
        if (!pix_written[y * FrameW + x]) push_write(x, y);
    for (k = 0; k < nrand; k++) begin
      r = $urandom_range(99);
      x = $urandom_range(plan_w - 1);
      y = $urandom_range(plan_h - 1);
      if (r < 40) begin
        push_write(x, y);
      end else if (r < 72) begin
        push_read(x, y);
      end else if (r < 80) begin
        push_cmd(mid_pkg::OP_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
      end else if (r < 93) begin
        // pick an address past the active edge where the frame leaves room
        if (plan_w < FrameW && (plan_h == FrameH || $urandom_range(1) == 1)) begin
          x = $urandom_range(63, plan_w);
          y = $urandom_range(63);
        end else if (plan_h < FrameH) begin
          x = $urandom_range(63);
          y = $urandom_range(63, plan_h);
        end
        if ($urandom_range(1) == 1) push_write(x, y);
        else push_read(x, y);
      end else begin
        push_cmd(OP_UNUSED, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
      end
    end
    wait_idle();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_cmd(cur_cmd));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
          cur_cmd = pending_cmds.pop_front();
          op         <= cur_cmd.op;
          pos_x      <= cur_cmd.pos_x;
          pos_y      <= cur_cmd.pos_y;
          red_in     <= cur_cmd.red;
          green_in   <= cur_cmd.green;
          blue_in    <= cur_cmd.blue;
          alpha_in   <= cur_cmd.alpha;
          mask_level <= cur_cmd.mask_level;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, expected none, got status %0d",
                   $time, status);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("alpha_out", want.alpha, alpha_out);
          check_field("masked_out", mid_pkg::ChanW'(want.masked), mid_pkg::ChanW'(masked_out));
          check_field("status", mid_pkg::ChanW'(want.status), mid_pkg::ChanW'(status));
          checked_cnt++;
        end
      end
      out_ready <= !hold_off && (quiet || $urandom_range(99) >= 13);
    end
  end

  // hold off the receiver once a backlog is queued
  initial begin
    while (!(accepted_cnt >= 40 && pending_cmds.size() > 50)) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
             awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned w, h, sw, r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // full-size image at reset settings
    push_cmd(mid_pkg::OP_WRITE, 0, 0, 'h00, 'h00, 'h00, 'h00, 'h00);
    push_cmd(mid_pkg::OP_WRITE, 63, 63, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
    push_cmd(mid_pkg::OP_WRITE, 1, 1, 'hA5, 'h5A, 'h0F, 'hF0, 127);
    push_read(0, 0);
    push_read(63, 63);
    push_read(1, 1);
    push_cmd(OP_UNUSED, 63, 63, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
    wait_idle();

    // zero size acts as a single pixel
    write_reg(mid_pkg::CFG_IMAGE_WIDTH, 0);
    write_reg(mid_pkg::CFG_IMAGE_HEIGHT, 0);
    push_cmd(mid_pkg::OP_WRITE, 0, 0, 'h12, 'h34, 'h56, 'h78, 128);
    push_write(1, 0);
    push_read(0, 1);
    push_read(0, 0);
    push_cmd(mid_pkg::OP_RUN, 0, 0, 'h00, 'h00, 'h00, 'h00, 'h00);
    wait_idle();

    // oversize clamps to the frame, zero sweeps leave it alone
    write_reg(mid_pkg::CFG_IMAGE_WIDTH, 127);
    write_reg(mid_pkg::CFG_IMAGE_HEIGHT, 127);
    write_reg(mid_pkg::CFG_SWEEP_COUNT, 0);
    write_reg(CFG_UNUSED, 'hFF);
    push_cmd(mid_pkg::OP_RUN, 63, 63, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF);
    push_read(63, 63);
    push_read(0, 0);
    wait_idle();

    run_phase(64, 3, 2, 120);
    run_phase(3, 64, 1, 120);
    run_phase(3, 3, 1, 60);
    run_phase(5, 5, 255, 40);
    run_phase(2, 10, 3, 60);
    run_phase(10, 2, 3, 60);
    run_phase(100, 4, 1, 80);
    run_phase(0, 5, 2, 40);
    run_phase(4, 4, 0, 60);
    while (pushed_cnt < TargetCmds) begin
      r = $urandom_range(99);
      if (r < 70) begin
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 10);
      end else if (r < 80) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(1, 12);
      end else if (r < 90) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(13, 127);
        h = 3;
      end
      if (w * h <= 25 && $urandom_range(9) == 0) sw = $urandom_range(5, 255);
      else sw = $urandom_range(0, 4);
      run_phase(w, h, sw, $urandom_range(60, 140));
    end
    repeat (50) @(posedge clk_i);

    $display("%0d commands checked over %0d phases, %0d register writes", checked_cnt,
             n_phases, n_cfg);
    $display("%0d writes, %0d reads, %0d runs, %0d out-of-range addresses", n_writes,
             n_reads, n_runs, n_rejected);
    if (fail_cnt == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, awaited_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
